// File: rtl/core/dcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_pkg
// Constants and types shared by the dotcode card checksum block.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int CountW = 12;

  localparam logic [CountW-1:0] HEAD_LEN   = 12'h00C;
  localparam logic [CountW-1:0] SHORT_LAST = 12'h51B;
  localparam logic [CountW-1:0] LONG_LAST  = 12'h81B;
  localparam logic [5:0]        BLOCK_LEN  = 6'h30;
  localparam logic [7:0]        SHORT_FIXED = 8'h27;
  localparam logic [7:0]        LONG_FIXED  = 8'h2A;

  typedef enum logic {
    KIND_SHORT = 1'b0,
    KIND_LONG  = 1'b1
  } card_kind_t;

  typedef struct packed {
    logic        last;
    logic [7:0]  header_xor;
    logic [15:0] word_check;
    logic [7:0]  global_check;
  } dcc_result_t;

endpackage
`default_nettype wire

// File: rtl/core/dotcode_card_checksum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotcode_card_checksum
// Checksums a dotcode card image streamed one byte per word.
// ----------------------------------------------------------------------------
// Takes one image byte per cycle with no gaps of its own. Each byte is held
// in an input register and folded into the accumulators from there; on the
// last byte of an image (0x51C or 0x81C bytes per card_kind) one result word
// is loaded into the output register as that byte is folded in, and the
// accumulators clear for the next image. The single accumulate step per byte
// sets the rate; only a result stalled at the output while the last byte of
// the following image arrives holds the input.
// ----------------------------------------------------------------------------
module dotcode_card_checksum
  import dcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_card_kind,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_header_xor,
  output logic [15:0]      out_word_check,
  output logic [7:0]       out_global_check
);

  card_kind_t  kind_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  logic [7:0]  hx_r;
  logic [15:0] wc_r;
  logic [7:0]  gc_r;

  dcc_result_t res;
  logic        s1_adv;
  logic        step;

  assign cfg_ready = 1'b1;

  dcc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (s1_byte_r),
    .card_kind (kind_r),
    .result    (res)
  );

  assign s1_adv   = !res.last || !out_valid_r || out_ready;
  assign step     = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_SHORT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        kind_r <= card_kind_t'(cfg_card_kind);
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (step && res.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
    if (step && res.last) begin
      hx_r <= res.header_xor;
      wc_r <= res.word_check;
      gc_r <= res.global_check;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_header_xor   = hx_r;
  assign out_word_check   = wc_r;
  assign out_global_check = gc_r;

  // held byte must not be lost while the stage stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input stage dropped a stalled byte");

  // a result only appears after an image-ending step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step && res.last))
    else $error("result raised without a last byte");

  // never overwrite a result that has not been taken
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.last) |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: rtl/core/dcc_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_accum
// Running header, pair-sum and block-XOR accumulators; clears at image end.
// ----------------------------------------------------------------------------
module dcc_accum
  import dcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire card_kind_t  card_kind,
  output dcc_result_t      result
);

  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]        head_xor_r, head_xor_nxt;
  logic [7:0]        head_sum_r, head_sum_nxt;
  logic [15:0]       pair_sum_r, pair_sum_nxt;
  logic [7:0]        block_xor_r, block_xor_nxt;
  logic [7:0]        block_tot_r, block_tot_nxt;
  logic [5:0]        block_pos_r, block_pos_nxt;

  logic [5:0]        pos_inc;
  logic [CountW-1:0] last_pos;
  logic [7:0]        fixed;
  logic [15:0]       wc;
  logic [7:0]        total;
  logic              last;

  always_comb begin
    head_xor_nxt  = head_xor_r;
    head_sum_nxt  = head_sum_r;
    pair_sum_nxt  = pair_sum_r;
    block_xor_nxt = block_xor_r;
    block_tot_nxt = block_tot_r;
    block_pos_nxt = block_pos_r;
    pos_inc       = block_pos_r + 6'd1;
    if (byte_count_r < HEAD_LEN) begin
      head_xor_nxt = head_xor_r ^ data_byte;
      head_sum_nxt = head_sum_r + data_byte;
    end else begin
      if (!byte_count_r[0]) begin
        pair_sum_nxt = pair_sum_r + {data_byte, 8'h00};
      end else begin
        pair_sum_nxt = pair_sum_r + {8'h00, data_byte};
      end
      block_xor_nxt = block_xor_r ^ data_byte;
      block_pos_nxt = pos_inc;
      if (pos_inc >= BLOCK_LEN) begin
        block_tot_nxt = block_tot_r + block_xor_nxt;
        block_xor_nxt = 8'h00;
        block_pos_nxt = 6'd0;
      end
    end

    last_pos = (card_kind == KIND_LONG) ? LONG_LAST : SHORT_LAST;
    fixed    = (card_kind == KIND_LONG) ? LONG_FIXED : SHORT_FIXED;
    last     = byte_count_r >= last_pos;
    byte_count_nxt = last ? '0 : byte_count_r + 12'd1;

    wc    = ~pair_sum_nxt;
    total = block_tot_nxt + block_xor_nxt;

    result.last         = last;
    result.header_xor   = head_xor_nxt;
    result.word_check   = wc;
    result.global_check = ~(fixed + head_sum_nxt + head_xor_nxt + wc[15:8] + wc[7:0] + total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      head_xor_r   <= '0;
      head_sum_r   <= '0;
      pair_sum_r   <= '0;
      block_xor_r  <= '0;
      block_tot_r  <= '0;
      block_pos_r  <= '0;
    end else if (step) begin
      if (last) begin
        byte_count_r <= '0;
        head_xor_r   <= '0;
        head_sum_r   <= '0;
        pair_sum_r   <= '0;
        block_xor_r  <= '0;
        block_tot_r  <= '0;
        block_pos_r  <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        head_xor_r   <= head_xor_nxt;
        head_sum_r   <= head_sum_nxt;
        pair_sum_r   <= pair_sum_nxt;
        block_xor_r  <= block_xor_nxt;
        block_tot_r  <= block_tot_nxt;
        block_pos_r  <= block_pos_nxt;
      end
    end
  end

endmodule
`default_nettype wire
